/* design/hts_pkg.sv */
// ============================================================================
// hts_pkg
// Shared constants, types and helpers for the HBM transaction splitter.
// ============================================================================
package hts_pkg;

    // Field widths
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 11;
    localparam int TID_W       = 16;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = 6;

    // Atom geometry and run limit
    localparam int MAX_ATOMS   = 64;
    localparam int ATOM_BYTES  = 32;
    localparam int OFS_W       = $clog2(ATOM_BYTES);
    localparam int CNT_W       = $clog2(MAX_ATOMS + 1);

    // Address map field widths and positions
    localparam int CH_W        = 3;
    localparam int COL_W       = 5;
    localparam int PCH_W       = 1;
    localparam int BG_W        = 2;
    localparam int BK_W        = 2;
    localparam int ROW_BITS    = 14;
    localparam int CH_LSB      = 5;
    localparam int COL_LSB     = 8;
    localparam int PCH_LSB     = 13;
    localparam int BG_LSB      = 14;
    localparam int BK_LSB      = 16;
    localparam int ROW_LSB     = 18;

    // Width of the length + offset + rounding sum
    localparam int SUM_W       = LEN_W + 1;

    // Mixed-radix atom counter, least significant digit last
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_W-1:0]    col;
        logic [BK_W-1:0]     bk;
        logic [BG_W-1:0]     bg;
        logic [PCH_W-1:0]    pch;
        logic [CH_W-1:0]     ch;
    } hts_ctr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new transaction
        logic step;     // advance to the next atom
    } hts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;    // incoming transaction has no atoms
        logic last;     // current atom ends the run
    } hts_stat_t;

    // Decode a byte address into the counter form
    function automatic hts_ctr_t hts_decode(input logic [ADDR_W-1:0] addr);
        hts_ctr_t c;
        c.ch  = addr[CH_LSB  +: CH_W];
        c.col = addr[COL_LSB +: COL_W];
        c.pch = addr[PCH_LSB +: PCH_W];
        c.bg  = addr[BG_LSB  +: BG_W];
        c.bk  = addr[BK_LSB  +: BK_W];
        c.row = addr[ROW_LSB +: ROW_BITS];
        return c;
    endfunction

    // Re-pack the counter into an atom address, offset bits zero
    function automatic logic [ADDR_W-1:0] hts_pack(input hts_ctr_t c);
        logic [ADDR_W-1:0] a;
        a = '0;
        a[CH_LSB  +: CH_W]     = c.ch;
        a[COL_LSB +: COL_W]    = c.col;
        a[PCH_LSB +: PCH_W]    = c.pch;
        a[BG_LSB  +: BG_W]     = c.bg;
        a[BK_LSB  +: BK_W]     = c.bk;
        a[ROW_LSB +: ROW_BITS] = c.row;
        return a;
    endfunction

endpackage

/* design/hts_ctrl.sv */
// ============================================================================
// hts_ctrl
// Run controller: accepts transactions and sequences atoms one per cycle.
// ============================================================================
module hts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hts_pkg::hts_stat_t st,
    output hts_pkg::hts_cmd_t  cmd,
    output logic              busy,
    output logic              atom_strobe
);
    import hts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic running;

    assign running     = (state_reg == S_RUN);
    assign atom_strobe = running;
    // a new transaction may enter while the final atom is on the ports
    assign busy        = running && !st.last;

    // commands to the datapath
    always_comb
    begin
        cmd.load = start && !busy;
        cmd.step = running && !st.last;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
        begin
            state_next = st.empty ? S_IDLE : S_RUN;
        end
        else if (running && st.last)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // busy only while atoms remain
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> atom_strobe)
        else $error("busy without a running transaction");

    // load and step never coincide
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("load and step in the same cycle");

    // a non-empty transaction produces an atom the next cycle
    a_first_atom: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !st.empty) |=> atom_strobe)
        else $error("accepted transaction produced no atom");

    // after the final atom the strobe drops unless a new transaction entered
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (atom_strobe && st.last && !start) |=> !atom_strobe)
        else $error("atom after end of run");

endmodule

/* design/hts_datapath.sv */
// ============================================================================
// hts_datapath
// Atom count, address counter and transaction fields for the splitter.
// ============================================================================
module hts_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hts_pkg::hts_cmd_t             cmd,
    output hts_pkg::hts_stat_t            st,
    input  logic                          req_type,
    input  logic [hts_pkg::ADDR_W-1:0]    byte_address,
    input  logic [hts_pkg::LEN_W-1:0]     byte_length,
    input  logic [hts_pkg::TID_W-1:0]     transaction_id,
    input  logic [hts_pkg::TIME_W-1:0]    start_time,
    output logic [hts_pkg::ADDR_W-1:0]    atom_address,
    output logic [hts_pkg::IDX_W-1:0]     atom_index,
    output logic                          atom_type,
    output logic [hts_pkg::TID_W-1:0]     atom_transaction,
    output logic [hts_pkg::TIME_W-1:0]    atom_start,
    output logic                          last_atom,
    output logic                          range_error
);
    import hts_pkg::*;

    localparam int CTR_W = $bits(hts_ctr_t);

    hts_ctr_t             ctr_reg;
    hts_ctr_t             ctr_next;
    logic                 carry;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_in;
    logic                 err_reg;
    logic                 type_reg;
    logic [TID_W-1:0]     tid_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-OFS_W-1:0] raw_cnt;
    logic [CNT_W-1:0]     idx_plus;

    // atom count: ceil((length + offset) / 32), saturated
    always_comb
    begin
        sum     = SUM_W'(byte_length) + SUM_W'(byte_address[OFS_W-1:0])
                + SUM_W'(ATOM_BYTES - 1);
        raw_cnt = sum[SUM_W-1:OFS_W];
        if (raw_cnt > (SUM_W-OFS_W)'(MAX_ATOMS))
        begin
            cnt_in = CNT_W'(MAX_ATOMS);
        end
        else
        begin
            cnt_in = CNT_W'(raw_cnt);
        end
    end

    // mixed-radix increment; carry out of the row flags a wrap
    assign {carry, ctr_next} = {1'b0, ctr_reg} + (CTR_W + 1)'(1);

    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);

    // status to the controller
    always_comb
    begin
        st.empty = (cnt_in == '0);
        st.last  = err_reg || (idx_plus == cnt_reg);
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            err_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= cnt_in;
        end
        else if (cmd.step)
        begin
            err_reg <= carry;
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ctr_reg  <= hts_decode(byte_address);
            type_reg <= req_type;
            tid_reg  <= transaction_id;
            time_reg <= start_time;
        end
        else if (cmd.step)
        begin
            ctr_reg <= ctr_next;
        end
    end

    // atom fields
    assign atom_address     = hts_pack(ctr_reg);
    assign atom_index       = idx_reg;
    assign atom_type        = type_reg;
    assign atom_transaction = tid_reg;
    assign atom_start       = time_reg;
    assign last_atom        = st.last;
    assign range_error      = err_reg;

endmodule

/* design/hbm_transaction_splitter_top.sv */
// ============================================================================
// hbm_transaction_splitter_top
// Splits a memory transaction into 32-byte HBM atom requests.
// ============================================================================
// The first atom appears in the cycle after start is accepted.
// Throughput: one atom per cycle; busy is high while a run shows any atom
//   but its last, and the next start is taken while the last atom shows.
// Atoms: ceil((length + address offset) / 32), capped at 64; a row wrap ends the
//   run early. An empty transaction is taken without raising busy.
// Reset clears the controller and run state; results cannot be stalled.
module hbm_transaction_splitter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [hts_pkg::ADDR_W-1:0]    byte_address,
    input  logic [hts_pkg::LEN_W-1:0]     byte_length,
    input  logic [hts_pkg::TID_W-1:0]     transaction_id,
    input  logic [hts_pkg::TIME_W-1:0]    start_time,
    output logic                          atom_strobe,
    output logic [hts_pkg::ADDR_W-1:0]    atom_address,
    output logic [hts_pkg::IDX_W-1:0]     atom_index,
    output logic                          atom_type,
    output logic [hts_pkg::TID_W-1:0]     atom_transaction,
    output logic [hts_pkg::TIME_W-1:0]    atom_start,
    output logic                          last_atom,
    output logic                          range_error
);
    import hts_pkg::*;

    hts_cmd_t  cmd;
    hts_stat_t st;

    // run controller
    hts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .st          (st),
        .cmd         (cmd),
        .busy        (busy),
        .atom_strobe (atom_strobe)
    );

    // address counter and fields
    hts_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .req_type         (req_type),
        .byte_address     (byte_address),
        .byte_length      (byte_length),
        .transaction_id   (transaction_id),
        .start_time       (start_time),
        .atom_address     (atom_address),
        .atom_index       (atom_index),
        .atom_type        (atom_type),
        .atom_transaction (atom_transaction),
        .atom_start       (atom_start),
        .last_atom        (last_atom),
        .range_error      (range_error)
    );

endmodule
